/* rtl/rcgc_pkg.sv */
`timescale 1ns / 1ps

package rcgc_pkg;

    localparam int DEF_MAX_NODES    = 64;
    localparam int DEF_MAX_EDGES    = 256;

    localparam int ID_W             = 6;
    localparam int OUT_CNT_W        = 9;
    localparam int NODE_COUNT_W     = 7;
    localparam int PADDR_W          = 3;
    localparam int PDATA_W          = 32;

    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

    // word index of each register (paddr[2])
    localparam logic REG_NODE_COUNT = 1'b0;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CLEAR,
        S_CNT_RD,
        S_CNT_REF,
        S_CNT_WR,
        S_SEED_RD,
        S_SEED_CHK,
        S_POP,
        S_POP_WAIT,
        S_SCAN_RD,
        S_SCAN_REF,
        S_SCAN_WR,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

    typedef enum logic {
        RD_IDX,
        RD_SRC
    } ref_rd_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_ZERO,
        WR_INC,
        WR_DEC
    } ref_wr_t;

    typedef struct packed {
        logic    load_en;
        logic    idx_clr;
        logic    idx_inc;
        logic    edge_clr;
        logic    edge_inc;
        ref_rd_t ref_rd;
        ref_wr_t ref_wr;
        logic    src_cap;
        logic    push_idx;
        logic    push_src;
        logic    pop;
        logic    popped_cap;
        logic    drop_set;
        logic    out_load;
        logic    graph_done;
    } cmd_t;

    typedef struct packed {
        logic last_accept;
        logic clear_end;
        logic idx_end;
        logic idx_last;
        logic edge_end;
        logic ids_ok;
        logic edge_hit;
        logic ref_zero;
        logic ref_one;
        logic stack_empty;
        logic out_busy;
    } sts_t;

endpackage

/* rtl/reference_count_graph_cull.sv */
`timescale 1ns / 1ps

// Dead node elimination by reference counting over a small directed graph.
// Input channel (in_valid / in_stall): one edge transfer per cycle while loading;
// edge_valid = 0 makes an empty transfer, last = 1 closes the graph (its edge,
// if any, is taken first). Edges with an id not below node_count (0 counts
// as 1), or beyond the edge table, are dropped and reported through edges_dropped.
// After last, in_stall stays high for the whole cull: a sweep clearing all
// MAX_NODES entries of the count memory, a pass over the stored edges to count
// out-degrees, a pass over the nodes to seed the stack, then per popped node a
// scan of the stored edges, then a walk emitting the results. The edge table
// scan per popped node (one memory port) sets the cull time.
// Output channel (out_valid / out_stall): one transfer per node, ids ascending,
// last_result on the highest id. A stalled result holds in the output register
// and the emit walk waits on it. Loading of the next graph starts as soon as
// the last result sits in the output register. Config: APB, node_count at byte
// address 0 (reset 64); the user must write it only when idle, the block does not check.
// Reset (rst_n low, asynchronous) empties the graph and returns to loading.
module reference_count_graph_cull #(
    parameter int MAX_NODES = rcgc_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = rcgc_pkg::DEF_MAX_EDGES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rcgc_pkg::PADDR_W-1:0]   paddr,
    input  logic [rcgc_pkg::PDATA_W-1:0]   pwdata,
    output logic [rcgc_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           edge_valid,
    input  logic [rcgc_pkg::ID_W-1:0]      from_node,
    input  logic [rcgc_pkg::ID_W-1:0]      to_node,
    input  logic                           last,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [rcgc_pkg::ID_W-1:0]      node_index,
    output logic                           culled,
    output logic [rcgc_pkg::OUT_CNT_W-1:0] reference_count,
    output logic                           edges_dropped,
    output logic                           last_result
);

    localparam int NCW = rcgc_pkg::NODE_COUNT_W;

    logic [NCW-1:0] node_count_reg;
    logic [NCW-1:0] n_eff;
    logic           cfg_wr;

    rcgc_pkg::cmd_t cmd;
    rcgc_pkg::sts_t sts;

    // register file: word index taken from paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == rcgc_pkg::REG_NODE_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= rcgc_pkg::NODE_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            node_count_reg <= pwdata[NCW-1:0];
        end
    end

    assign prdata = (paddr[2] == rcgc_pkg::REG_NODE_COUNT)
                    ? rcgc_pkg::PDATA_W'(node_count_reg) : '0;

    // zero counts as one node, anything above capacity is clamped
    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_eff = NCW'(1);
        end
        else if (node_count_reg > NCW'(MAX_NODES))
        begin
            n_eff = NCW'(MAX_NODES);
        end
        else
        begin
            n_eff = node_count_reg;
        end
    end

    rcgc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    rcgc_dpath #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .n_eff           (n_eff),
        .cmd             (cmd),
        .sts             (sts),
        .in_valid        (in_valid),
        .edge_valid      (edge_valid),
        .from_node       (from_node),
        .to_node         (to_node),
        .last            (last),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .node_index      (node_index),
        .culled          (culled),
        .reference_count (reference_count),
        .edges_dropped   (edges_dropped),
        .last_result     (last_result)
    );

    assign in_stall = !cmd.load_en;

    // the cull never pops an empty stack
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !sts.stack_empty)
        else $error("pop issued on empty stack");

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid && out_stall))
        else $error("result loaded over a stalled result");

    // a stalled result stays put
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(node_index)
                                      && $stable(reference_count)))
        else $error("stalled result changed");

endmodule

/* rtl/rcgc_ram.sv */
`timescale 1ns / 1ps

module rcgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/rcgc_ctrl.sv */
`timescale 1ns / 1ps

module rcgc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  rcgc_pkg::sts_t  sts,
    output rcgc_pkg::cmd_t  cmd
);

    rcgc_pkg::state_t state_reg;
    rcgc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rcgc_pkg::S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.ref_rd = rcgc_pkg::RD_IDX;
        cmd.ref_wr = rcgc_pkg::WR_NONE;
        unique case (state_reg)
            rcgc_pkg::S_LOAD:
            begin
                cmd.load_en = 1'b1;
                if (sts.last_accept)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = rcgc_pkg::S_CLEAR;
                end
            end
            rcgc_pkg::S_CLEAR:
            begin
                cmd.ref_wr = rcgc_pkg::WR_ZERO;
                if (sts.clear_end)
                begin
                    cmd.idx_clr  = 1'b1;
                    cmd.edge_clr = 1'b1;
                    state_next   = rcgc_pkg::S_CNT_RD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            rcgc_pkg::S_CNT_RD:
            begin
                state_next = sts.edge_end ? rcgc_pkg::S_SEED_RD : rcgc_pkg::S_CNT_REF;
            end
            rcgc_pkg::S_CNT_REF:
            begin
                cmd.src_cap = 1'b1;
                if (sts.ids_ok)
                begin
                    cmd.ref_rd = rcgc_pkg::RD_SRC;
                    state_next = rcgc_pkg::S_CNT_WR;
                end
                else
                begin
                    cmd.drop_set = 1'b1;
                    cmd.edge_inc = 1'b1;
                    state_next   = rcgc_pkg::S_CNT_RD;
                end
            end
            rcgc_pkg::S_CNT_WR:
            begin
                cmd.ref_wr   = rcgc_pkg::WR_INC;
                cmd.edge_inc = 1'b1;
                state_next   = rcgc_pkg::S_CNT_RD;
            end
            rcgc_pkg::S_SEED_RD:
            begin
                if (sts.idx_end)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = rcgc_pkg::S_POP;
                end
                else
                begin
                    state_next = rcgc_pkg::S_SEED_CHK;
                end
            end
            rcgc_pkg::S_SEED_CHK:
            begin
                cmd.push_idx = sts.ref_zero;
                cmd.idx_inc  = 1'b1;
                state_next   = rcgc_pkg::S_SEED_RD;
            end
            rcgc_pkg::S_POP:
            begin
                if (sts.stack_empty)
                begin
                    state_next = rcgc_pkg::S_EMIT_RD;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = rcgc_pkg::S_POP_WAIT;
                end
            end
            rcgc_pkg::S_POP_WAIT:
            begin
                cmd.popped_cap = 1'b1;
                cmd.edge_clr   = 1'b1;
                state_next     = rcgc_pkg::S_SCAN_RD;
            end
            rcgc_pkg::S_SCAN_RD:
            begin
                state_next = sts.edge_end ? rcgc_pkg::S_POP : rcgc_pkg::S_SCAN_REF;
            end
            rcgc_pkg::S_SCAN_REF:
            begin
                cmd.src_cap = 1'b1;
                if (sts.edge_hit)
                begin
                    cmd.ref_rd = rcgc_pkg::RD_SRC;
                    state_next = rcgc_pkg::S_SCAN_WR;
                end
                else
                begin
                    cmd.edge_inc = 1'b1;
                    state_next   = rcgc_pkg::S_SCAN_RD;
                end
            end
            rcgc_pkg::S_SCAN_WR:
            begin
                if (!sts.ref_zero)
                begin
                    cmd.ref_wr   = rcgc_pkg::WR_DEC;
                    cmd.push_src = sts.ref_one;
                end
                cmd.edge_inc = 1'b1;
                state_next   = rcgc_pkg::S_SCAN_RD;
            end
            rcgc_pkg::S_EMIT_RD:
            begin
                state_next = rcgc_pkg::S_EMIT_OUT;
            end
            rcgc_pkg::S_EMIT_OUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.idx_last)
                    begin
                        cmd.graph_done = 1'b1;
                        cmd.idx_clr    = 1'b1;
                        state_next     = rcgc_pkg::S_LOAD;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = rcgc_pkg::S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = rcgc_pkg::S_LOAD;
            end
        endcase
    end

endmodule

/* rtl/rcgc_dpath.sv */
`timescale 1ns / 1ps

module rcgc_dpath #(
    parameter int MAX_NODES = rcgc_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = rcgc_pkg::DEF_MAX_EDGES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [rcgc_pkg::NODE_COUNT_W-1:0] n_eff,
    input  rcgc_pkg::cmd_t                    cmd,
    output rcgc_pkg::sts_t                    sts,
    input  logic                              in_valid,
    input  logic                              edge_valid,
    input  logic [rcgc_pkg::ID_W-1:0]         from_node,
    input  logic [rcgc_pkg::ID_W-1:0]         to_node,
    input  logic                              last,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [rcgc_pkg::ID_W-1:0]         node_index,
    output logic                              culled,
    output logic [rcgc_pkg::OUT_CNT_W-1:0]    reference_count,
    output logic                              edges_dropped,
    output logic                              last_result
);

    localparam int IDW = rcgc_pkg::ID_W;
    localparam int NCW = rcgc_pkg::NODE_COUNT_W;
    localparam int OCW = rcgc_pkg::OUT_CNT_W;
    localparam int NW  = $clog2(MAX_NODES + 1);
    localparam int RAW = $clog2(MAX_NODES);
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int EAW = $clog2(MAX_EDGES);
    localparam int CW  = $clog2(MAX_EDGES + 1);

    logic [NW-1:0]    idx_reg;
    logic [EW-1:0]    e_reg;
    logic [EW-1:0]    total_reg;
    logic [NW-1:0]    depth_reg;
    logic [IDW-1:0]   src_reg;
    logic [IDW-1:0]   popped_reg;
    logic             drop_reg;

    logic             out_valid_reg;
    logic [IDW-1:0]   out_index_reg;
    logic             out_culled_reg;
    logic [OCW-1:0]   out_count_reg;
    logic             out_drop_reg;
    logic             out_last_reg;

    logic             in_accept;
    logic             in_ids_ok;
    logic             edge_we;

    logic [2*IDW-1:0] edge_rdata;
    logic [IDW-1:0]   e_src;
    logic [IDW-1:0]   e_dst;

    logic             ref_we;
    logic [RAW-1:0]   ref_waddr;
    logic [CW-1:0]    ref_wdata;
    logic [RAW-1:0]   ref_raddr;
    logic [CW-1:0]    ref_rdata;

    logic             push;
    logic [IDW-1:0]   push_id;
    logic [NW-1:0]    depth_m1;
    logic [IDW-1:0]   stack_rdata;

    logic [CW+OCW-1:0] cnt_wide;
    logic [OCW-1:0]    cnt_sat;

    assign in_accept = in_valid && cmd.load_en;
    assign in_ids_ok = (NCW'(from_node) < n_eff) && (NCW'(to_node) < n_eff);
    assign edge_we   = in_accept && edge_valid && in_ids_ok
                       && (total_reg < EW'(MAX_EDGES));

    assign e_src = edge_rdata[2*IDW-1:IDW];
    assign e_dst = edge_rdata[IDW-1:0];

    // edge table: source in the upper half, target in the lower
    rcgc_ram #(
        .WIDTH (2 * IDW),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (total_reg[EAW-1:0]),
        .wdata ({from_node, to_node}),
        .raddr (e_reg[EAW-1:0]),
        .rdata (edge_rdata)
    );

    always_comb
    begin
        ref_we    = 1'b1;
        ref_waddr = src_reg[RAW-1:0];
        ref_wdata = ref_rdata;
        case (cmd.ref_wr)
            rcgc_pkg::WR_ZERO:
            begin
                ref_waddr = idx_reg[RAW-1:0];
                ref_wdata = '0;
            end
            rcgc_pkg::WR_INC: ref_wdata = ref_rdata + CW'(1);
            rcgc_pkg::WR_DEC: ref_wdata = ref_rdata - CW'(1);
            default:          ref_we    = 1'b0;
        endcase
    end

    assign ref_raddr = (cmd.ref_rd == rcgc_pkg::RD_SRC) ? e_src[RAW-1:0] : idx_reg[RAW-1:0];

    rcgc_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_NODES)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ref_waddr),
        .wdata (ref_wdata),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    assign push     = (cmd.push_idx || cmd.push_src) && (depth_reg < NW'(MAX_NODES));
    assign push_id  = cmd.push_src ? src_reg : IDW'(idx_reg);
    assign depth_m1 = depth_reg - NW'(1);

    rcgc_ram #(
        .WIDTH (IDW),
        .DEPTH (MAX_NODES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (push),
        .waddr (depth_reg[RAW-1:0]),
        .wdata (push_id),
        .raddr (depth_m1[RAW-1:0]),
        .rdata (stack_rdata)
    );

    assign cnt_wide = (CW+OCW)'(ref_rdata);
    assign cnt_sat  = (cnt_wide > (CW+OCW)'((1 << OCW) - 1)) ? '1 : cnt_wide[OCW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            e_reg         <= '0;
            total_reg     <= '0;
            depth_reg     <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + NW'(1);
            end

            if (cmd.edge_clr)
            begin
                e_reg <= '0;
            end
            else if (cmd.edge_inc)
            begin
                e_reg <= e_reg + EW'(1);
            end

            if (cmd.graph_done)
            begin
                total_reg <= '0;
            end
            else if (edge_we)
            begin
                total_reg <= total_reg + EW'(1);
            end

            if (push)
            begin
                depth_reg <= depth_reg + NW'(1);
            end
            else if (cmd.pop)
            begin
                depth_reg <= depth_m1;
            end

            if (cmd.graph_done)
            begin
                drop_reg <= 1'b0;
            end
            else if (cmd.drop_set || (in_accept && edge_valid && !edge_we))
            begin
                drop_reg <= 1'b1;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.src_cap)
        begin
            src_reg <= e_src;
        end
        if (cmd.popped_cap)
        begin
            popped_reg <= stack_rdata;
        end
        if (cmd.out_load)
        begin
            out_index_reg  <= IDW'(idx_reg);
            out_culled_reg <= (ref_rdata == '0);
            out_count_reg  <= cnt_sat;
            out_drop_reg   <= drop_reg;
            out_last_reg   <= sts.idx_last;
        end
    end

    always_comb
    begin
        sts.last_accept = in_accept && last;
        sts.clear_end   = (idx_reg == NW'(MAX_NODES - 1));
        sts.idx_end     = (NCW'(idx_reg) == n_eff);
        sts.idx_last    = ((NCW'(idx_reg) + NCW'(1)) == n_eff);
        sts.edge_end    = (e_reg == total_reg);
        sts.ids_ok      = (NCW'(e_src) < n_eff) && (NCW'(e_dst) < n_eff);
        sts.edge_hit    = sts.ids_ok && (e_dst == popped_reg);
        sts.ref_zero    = (ref_rdata == '0);
        sts.ref_one     = (ref_rdata == CW'(1));
        sts.stack_empty = (depth_reg == '0);
        sts.out_busy    = out_valid_reg && out_stall;
    end

    assign out_valid       = out_valid_reg;
    assign node_index      = out_index_reg;
    assign culled          = out_culled_reg;
    assign reference_count = out_count_reg;
    assign edges_dropped   = out_drop_reg;
    assign last_result     = out_last_reg;

endmodule

/* test/tb_reference_count_graph_cull.sv */
`timescale 1ns / 1ps

// Testbench for the reference-count graph cull.
// Edge transfers are queued by the stimulus process and offered by a clocked
// driver. A clocked monitor checks each result transfer against the expected
// node reports. Those reports are computed by a behavioural cull when a last
// transfer is accepted.
module tb_reference_count_graph_cull;

    localparam int NODES_MAX = rcgc_pkg::DEF_MAX_NODES;
    localparam int EDGES_MAX = rcgc_pkg::DEF_MAX_EDGES;
    localparam int IDW       = rcgc_pkg::ID_W;
    localparam int OCW       = rcgc_pkg::OUT_CNT_W;
    localparam int AW        = rcgc_pkg::PADDR_W;
    localparam int DW        = rcgc_pkg::PDATA_W;

    typedef struct packed {
        logic           has_edge;
        logic [IDW-1:0] src;
        logic [IDW-1:0] dst;
        logic           close;
    } edge_item_t;

    typedef struct packed {
        logic [IDW-1:0] id;
        logic           dead;
        logic [OCW-1:0] refs;
        logic           dropped;
        logic           final_node;
    } node_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [AW-1:0] paddr = '0;
    logic [DW-1:0] pwdata = '0;
    logic [DW-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic edge_valid = 1'b0;
    logic [IDW-1:0] from_node = '0, to_node = '0;
    logic last = 1'b0;
    logic out_valid;
    logic out_stall = 1'b1;
    logic [IDW-1:0] node_index;
    logic culled;
    logic [OCW-1:0] reference_count;
    logic edges_dropped;
    logic last_result;

    reference_count_graph_cull uut (.*);

    always #5 clk = ~clk;

    // ---------------- behavioural cull ----------------
    int unsigned       nodes_cfg = 64;
    logic [IDW-1:0]    tbl_src [EDGES_MAX];
    logic [IDW-1:0]    tbl_dst [EDGES_MAX];
    int unsigned       tbl_fill = 0;
    bit                any_dropped = 0;

    edge_item_t   edge_queue[$];
    node_report_t report_queue[$];

    int  fail_count = 0;
    int  reports_seen = 0;
    int  graphs_closed = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  recv_hold = 0;

    // Take one accepted transfer; on close, run the cull and queue reports.
    function automatic void absorb_edge(edge_item_t it);
        int unsigned n;
        int unsigned refs [NODES_MAX];
        int unsigned stack [$];
        int unsigned popped;
        node_report_t rep;
        n = (nodes_cfg == 0) ? 1 : (nodes_cfg > NODES_MAX ? NODES_MAX : nodes_cfg);
        if (it.has_edge)
        begin
            if (it.src >= n || it.dst >= n || tbl_fill >= EDGES_MAX)
                any_dropped = 1;
            else
            begin
                tbl_src[tbl_fill] = it.src;
                tbl_dst[tbl_fill] = it.dst;
                tbl_fill++;
            end
        end
        if (!it.close)
            return;
        foreach (refs[i])
            refs[i] = 0;
        // out-degree; stale edges after a lowered count are ignored and flagged
        for (int e = 0; e < tbl_fill; e++)
        begin
            if (tbl_src[e] >= n || tbl_dst[e] >= n)
                any_dropped = 1;
            else
                refs[tbl_src[e]]++;
        end
        for (int i = 0; i < n; i++)
            if (refs[i] == 0)
                stack.push_front(i);
        while (stack.size() > 0)
        begin
            popped = stack.pop_front();
            for (int e = 0; e < tbl_fill; e++)
            begin
                if (tbl_src[e] >= n || tbl_dst[e] >= n || tbl_dst[e] != popped)
                    continue;
                if (refs[tbl_src[e]] > 0)
                begin
                    refs[tbl_src[e]]--;
                    if (refs[tbl_src[e]] == 0)
                        stack.push_front(tbl_src[e]);
                end
            end
        end
        for (int i = 0; i < n; i++)
        begin
            rep = '{id: i[IDW-1:0], dead: refs[i] == 0,
                refs: (refs[i] > 511) ? 9'd511 : refs[i][OCW-1:0],
                dropped: any_dropped, final_node: (i + 1 == n)};
            report_queue.insert(report_queue.size(), rep);
        end
        tbl_fill = 0;
        any_dropped = 0;
        graphs_closed++;
    endfunction

    // ---------------- driver ----------------
    // Valid is decided without looking at stall; a held transfer keeps its payload.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                absorb_edge('{edge_valid, from_node, to_node, last});
            if (!in_valid || !in_stall)
            begin
                if (edge_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    edge_item_t nx;
                    nx = edge_queue.pop_front();
                    in_valid   <= 1'b1;
                    edge_valid <= nx.has_edge;
                    from_node  <= nx.src;
                    to_node    <= nx.dst;
                    last       <= nx.close;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                reports_seen++;
                if (report_queue.size() == 0)
                begin
                    $error("unexpected result transfer, node_index %0d", node_index);
                    fail_count++;
                end
                else
                begin
                    node_report_t x;
                    x = report_queue.pop_front();
                    if (node_index !== x.id)
                    begin
                        $error("node_index: expected %0d, got %0d", x.id, node_index);
                        fail_count++;
                    end
                    if (culled !== x.dead)
                    begin
                        $error("culled: expected %0d, got %0d", x.dead, culled);
                        fail_count++;
                    end
                    if (reference_count !== x.refs)
                    begin
                        $error("reference_count: expected %0d, got %0d",
                               x.refs, reference_count);
                        fail_count++;
                    end
                    if (edges_dropped !== x.dropped)
                    begin
                        $error("edges_dropped: expected %0d, got %0d",
                               x.dropped, edges_dropped);
                        fail_count++;
                    end
                    if (last_result !== x.final_node)
                    begin
                        $error("last_result: expected %0d, got %0d",
                               x.final_node, last_result);
                        fail_count++;
                    end
                end
            end
            out_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic add_edge(input logic v, input int s, input int d, input logic c);
        edge_item_t it;
        it = '{v, s[IDW-1:0], d[IDW-1:0], c};
        edge_queue.insert(edge_queue.size(), it);
    endtask

    task automatic apb_write(input logic [AW-1:0] a, input int unsigned v);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        nodes_cfg = v & 7'h7f;
    endtask

    // Wait until all queued transfers are taken and all reports are back,
    // then let the tail of the cull settle.
    task automatic drain();
        while (edge_queue.size() > 0 || in_valid || report_queue.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Random graph: mostly in-range edges over n nodes, some noise.
    task automatic random_graph(input int n, input int edges);
        int hi;
        hi = (n > 64) ? 63 : ((n < 1) ? 0 : n - 1);
        for (int k = 0; k < edges; k++)
        begin
            if ($urandom_range(19) == 0)
                add_edge(1'b0, $urandom_range(63), $urandom_range(63), 1'b0);
            else if ($urandom_range(24) == 0)
                add_edge(1'b1, $urandom_range(63), $urandom_range(63), 1'b0);
            else
                add_edge(1'b1, $urandom_range(hi), $urandom_range(hi), 1'b0);
        end
        add_edge($urandom_range(1), $urandom_range(hi), $urandom_range(hi), 1'b1);
    endtask

    localparam logic [AW-1:0] NODE_COUNT_ADDR = {rcgc_pkg::REG_NODE_COUNT, 2'b00};

    // ---------------- main sequence ----------------
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: chain with a cycle at reset count (64 nodes, extreme ids).
        add_edge(1'b1, 0, 63, 1'b0);
        add_edge(1'b1, 63, 62, 1'b0);
        add_edge(1'b1, 5, 6, 1'b0);
        add_edge(1'b1, 6, 5, 1'b0);   // cycle keeps both alive
        add_edge(1'b1, 7, 7, 1'b0);   // self loop
        add_edge(1'b0, 63, 63, 1'b0);
        add_edge(1'b1, 62, 0, 1'b1);  // edge on the closing transfer
        drain();

        // Single node: count 0 behaves as 1, bad ids dropped.
        apb_write(NODE_COUNT_ADDR, 0);
        add_edge(1'b1, 0, 0, 1'b0);
        add_edge(1'b1, 1, 0, 1'b0);
        add_edge(1'b0, 0, 0, 1'b1);
        drain();
        apb_write(NODE_COUNT_ADDR, 1);
        add_edge(1'b0, 42, 21, 1'b1); // empty graph, close only
        drain();

        // Count above the maximum is clamped.
        apb_write(NODE_COUNT_ADDR, 127);
        add_edge(1'b1, 1, 2, 1'b0);
        add_edge(1'b1, 2, 3, 1'b1);
        drain();

        // Table overflow: 260 transfers, each with an edge, over 4 nodes, with a long
        // receiver hold while the next graph keeps offering transfers.
        apb_write(NODE_COUNT_ADDR, 4);
        for (int k = 0; k < 260; k++)
            add_edge(1'b1, k % 4, (k + 1) % 4, k == 259);
        random_graph(4, 9);           // queued back to back behind the overflow
        drain();

        // Random phases with varied counts and idling.
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 10 : ((ph == 1) ? 75 : 0);
            recv_idle_pct = (ph == 0) ? 75 : ((ph == 1) ? 10 : 0);
            for (int g = 0; g < 2; g++)
            begin
                int n;
                case ($urandom_range(3))
                    0: n = 2;
                    1: n = 64;
                    default: n = $urandom_range(1, 64);
                endcase
                apb_write(NODE_COUNT_ADDR, n);
                random_graph(n, $urandom_range(2, 8));
                if (ph == 2 && g == 1)
                    random_graph(n, 5);   // queued back to back for pressure
                drain();
            end
        end

        // Lowered count after loading: stale edges are ignored and flagged.
        apb_write(NODE_COUNT_ADDR, 64);
        add_edge(1'b1, 50, 1, 1'b0);
        add_edge(1'b1, 1, 2, 1'b0);
        while (edge_queue.size() > 0 || in_valid)
            @(posedge clk);
        repeat (5) @(posedge clk);
        apb_write(NODE_COUNT_ADDR, 8);
        add_edge(1'b0, 0, 0, 1'b1);
        drain();

        $display("Run covered %0d graphs, %0d node reports checked.",
                 graphs_closed, reports_seen);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Long receiver hold once the overflow graph closes, counted here; the
    // following graph is offered meanwhile.
    initial
    begin
        wait (graphs_closed == 5);
        recv_hold = 1;
        repeat (2000) @(posedge clk);
        recv_hold = 0;
    end

    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

/* filelist.f */
rtl/rcgc_pkg.sv
rtl/rcgc_ram.sv
rtl/rcgc_ctrl.sv
rtl/rcgc_dpath.sv
rtl/reference_count_graph_cull.sv
test/tb_reference_count_graph_cull.sv
